// ===== sv/dtrp_pkg.sv =====
// shared types, event codes and helpers for the disk image track record parser
// no dependencies

package dtrp_pkg;

    localparam int MAX_SIZE_CODE = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] END_OF_COMMENT = 8'h1a;
    localparam logic [7:0] TYPE_ABSENT = 8'h00;
    localparam logic [7:0] TYPE_FILL = 8'h02;

    localparam logic [3:0] EV_HEADER = 4'd0;
    localparam logic [3:0] EV_SECMAP = 4'd1;
    localparam logic [3:0] EV_CYLMAP = 4'd2;
    localparam logic [3:0] EV_HEADMAP = 4'd3;
    localparam logic [3:0] EV_DATA = 4'd4;
    localparam logic [3:0] EV_FILL = 4'd5;
    localparam logic [3:0] EV_ABSENT = 4'd6;
    localparam logic [3:0] EV_END = 4'd7;
    localparam logic [3:0] EV_ERROR = 4'd8;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       is_end;
    } dtrp_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [7:0]  track_cylinder;
        logic [5:0]  track_head;
        logic [7:0]  track_mode;
        logic [7:0]  sector_count;
        logic [13:0] sector_bytes;
        logic [7:0]  sector_index;
        logic [12:0] byte_offset;
        logic [7:0]  value;
        logic        last_in_sector;
        logic        last_of_track;
    } dtrp_result_t;

    // compact event record passed from the parser to the output stage
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  cylinder;
        logic [5:0]  head;
        logic [7:0]  mode;
        logic [7:0]  count;
        logic [2:0]  size_code;
        logic [7:0]  index;
        logic [12:0] offset;
        logic [7:0]  value;
        logic        last_in_sector;
        logic        last_of_track;
    } dtrp_rec_t;

    function automatic logic [13:0] sector_size(input logic [2:0] code);
        logic [13:0] base;
        base = 14'h0080;
        return base << code;
    endfunction

endpackage

// ===== sv/disk_image_track_record_parser.sv =====
// top level of the disk image track record parser
// depends on dtrp_pkg, dtrp_front, dtrp_queue, dtrp_back

// Takes one image byte per beat and produces at most one tagged result per byte. Bytes are
// accepted every cycle as long as the four-entry record queue between the parser and the
// output register has room, so the sustained rate is one byte per cycle, with each result
// going through the queue and then the output register; a stalled result side fills the
// queue and then holds off input. Comment bytes, header bytes before the size code and
// sector type bytes other than absent give no result. After a clean end or an error the
// parser swallows every further byte without a result until reset.

module disk_image_track_record_parser
    import dtrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  dtrp_item_t   item,
    output logic         result_valid,
    input  logic         result_ready,
    output dtrp_result_t result
);

    logic      push;
    dtrp_rec_t push_rec;
    logic      not_full;
    logic      pop;
    logic      not_empty;
    dtrp_rec_t head_rec;

    assign item_ready = not_full;

    dtrp_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (item_valid && not_full),
        .item   (item),
        .push   (push),
        .rec    (push_rec)
    );

    dtrp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    dtrp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (not_empty),
        .rec          (head_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== sv/dtrp_front.sv =====
// parser front end: accepts image bytes, tracks phase and counters, emits event records
// depends on dtrp_pkg

module dtrp_front
    import dtrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  dtrp_item_t item,
    output logic       push,
    output dtrp_rec_t  rec
);

    localparam logic [2:0] PH_COMMENT = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SECMAP = 3'd2;
    localparam logic [2:0] PH_CYLMAP = 3'd3;
    localparam logic [2:0] PH_HEADMAP = 3'd4;
    localparam logic [2:0] PH_TYPE = 3'd5;
    localparam logic [2:0] PH_FILL = 3'd6;
    localparam logic [2:0] PH_DATA = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  cyl_reg, cyl_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  count_reg, count_next;
    logic [2:0]  size_reg, size_next;
    logic [7:0]  entry_reg, entry_next;
    logic [12:0] bcount_reg, bcount_next;
    logic        halted_reg, halted_next;

    logic        emit;
    logic [3:0]  kind;
    logic [7:0]  idx;
    logic [12:0] off;
    logic [7:0]  val;
    logic        lis;
    logic        lot;
    logic        entry_last;
    logic        data_last;
    logic [7:0]  b;

    assign b = item.byte_in;
    assign entry_last = ({1'b0, entry_reg} + 9'd1) >= {1'b0, count_reg};
    assign data_last = ({1'b0, bcount_reg} + 14'd1) >= sector_size(size_reg);

    always_comb
    begin
        phase_next = phase_reg;
        mode_next = mode_reg;
        cyl_next = cyl_reg;
        flags_next = flags_reg;
        count_next = count_reg;
        size_next = size_reg;
        entry_next = entry_reg;
        bcount_next = bcount_reg;
        halted_next = halted_reg;
        emit = 1'b0;
        kind = EV_HEADER;
        idx = 8'd0;
        off = 13'd0;
        val = 8'd0;
        lis = 1'b0;
        lot = 1'b0;

        if (accept && !halted_reg)
        begin
            if (item.is_end)
            begin
                halted_next = 1'b1;
                emit = 1'b1;
                kind = (phase_reg == PH_HEADER && entry_reg == 8'd0) ? EV_END : EV_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_COMMENT:
                    begin
                        if (b == END_OF_COMMENT)
                        begin
                            phase_next = PH_HEADER;
                            entry_next = 8'd0;
                        end
                    end
                    PH_HEADER:
                    begin
                        unique case (entry_reg)
                            8'd0: mode_next = b;
                            8'd1: cyl_next = b;
                            8'd2: flags_next = b;
                            8'd3: count_next = b;
                            default: ;
                        endcase
                        if (entry_reg < 8'd4)
                            entry_next = entry_reg + 8'd1;
                        else if (b > 8'(MAX_SIZE_CODE))
                        begin
                            halted_next = 1'b1;
                            emit = 1'b1;
                            kind = EV_ERROR;
                        end
                        else
                        begin
                            size_next = b[2:0];
                            entry_next = 8'd0;
                            emit = 1'b1;
                            kind = EV_HEADER;
                            if (count_reg == 8'd0)
                                lot = 1'b1;
                            else
                                phase_next = PH_SECMAP;
                        end
                    end
                    PH_SECMAP, PH_CYLMAP, PH_HEADMAP:
                    begin
                        emit = 1'b1;
                        kind = 4'(phase_reg - 3'd1);
                        idx = entry_reg;
                        val = b;
                        if (entry_last)
                        begin
                            entry_next = 8'd0;
                            priority if (phase_reg == PH_SECMAP && flags_reg[7])
                                phase_next = PH_CYLMAP;
                            else if (phase_reg != PH_HEADMAP && flags_reg[6])
                                phase_next = PH_HEADMAP;
                            else
                                phase_next = PH_TYPE;
                        end
                        else
                            entry_next = entry_reg + 8'd1;
                    end
                    PH_TYPE:
                    begin
                        if (b == TYPE_ABSENT)
                        begin
                            emit = 1'b1;
                            kind = EV_ABSENT;
                            idx = entry_reg;
                            lis = 1'b1;
                        end
                        else if (b == TYPE_FILL)
                            phase_next = PH_FILL;
                        else
                        begin
                            phase_next = PH_DATA;
                            bcount_next = 13'd0;
                        end
                    end
                    PH_FILL:
                    begin
                        emit = 1'b1;
                        kind = EV_FILL;
                        idx = entry_reg;
                        val = b;
                        lis = 1'b1;
                    end
                    PH_DATA:
                    begin
                        emit = 1'b1;
                        kind = EV_DATA;
                        idx = entry_reg;
                        off = bcount_reg;
                        val = b;
                        if (data_last)
                        begin
                            bcount_next = 13'd0;
                            lis = 1'b1;
                        end
                        else
                            bcount_next = bcount_reg + 13'd1;
                    end
                    default: ;
                endcase

                // end of a sector record: advance to next sector or next header
                if (lis)
                begin
                    if (entry_last)
                    begin
                        phase_next = PH_HEADER;
                        entry_next = 8'd0;
                        lot = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                        entry_next = entry_reg + 8'd1;
                    end
                end
            end
        end
    end

    assign push = emit;

    always_comb
    begin
        rec.kind = kind;
        rec.cylinder = cyl_next;
        rec.head = flags_next[5:0];
        rec.mode = mode_next;
        rec.count = count_next;
        rec.size_code = size_next;
        rec.index = idx;
        rec.offset = off;
        rec.value = val;
        rec.last_in_sector = lis;
        rec.last_of_track = lot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COMMENT;
            mode_reg <= 8'd0;
            cyl_reg <= 8'd0;
            flags_reg <= 8'd0;
            count_reg <= 8'd0;
            size_reg <= 3'd0;
            entry_reg <= 8'd0;
            bcount_reg <= 13'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg <= mode_next;
            cyl_reg <= cyl_next;
            flags_reg <= flags_next;
            count_reg <= count_next;
            size_reg <= size_next;
            entry_reg <= entry_next;
            bcount_reg <= bcount_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== sv/dtrp_queue.sv =====
// short event record queue between parser and output stage
// depends on dtrp_pkg

module dtrp_queue
    import dtrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  dtrp_rec_t push_rec,
    output logic      not_full,
    input  logic      pop,
    output logic      not_empty,
    output dtrp_rec_t head_rec
);

    dtrp_rec_t            slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    fill_reg, fill_next;

    assign not_full = fill_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next = fill_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== sv/dtrp_back.sv =====
// output stage: expands queued event records into result beats and holds them
// depends on dtrp_pkg

module dtrp_back
    import dtrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         rec_valid,
    input  dtrp_rec_t    rec,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_ready,
    output dtrp_result_t result
);

    logic         valid_reg, valid_next;
    dtrp_result_t result_reg, result_next;

    assign pop = rec_valid && (!valid_reg || result_ready);

    always_comb
    begin
        result_next.event_kind = rec.kind;
        result_next.track_cylinder = rec.cylinder;
        result_next.track_head = rec.head;
        result_next.track_mode = rec.mode;
        result_next.sector_count = rec.count;
        result_next.sector_bytes = sector_size(rec.size_code);
        result_next.sector_index = rec.index;
        result_next.byte_offset = rec.offset;
        result_next.value = rec.value;
        result_next.last_in_sector = rec.last_in_sector;
        result_next.last_of_track = rec.last_of_track;
        valid_next = pop || (valid_reg && !result_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign result_valid = valid_reg;
    assign result = result_reg;

endmodule

// ===== tb/tb_track_record_checker.sv =====
`timescale 1ns / 1ps
// checker for the disk image track record parser: watches both channels, decodes the
// accepted bytes itself and compares every result beat; depends on dtrp_pkg

module tb_track_record_checker
    import dtrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_ready,
    input  dtrp_item_t   item,
    input  logic         result_valid,
    input  logic         result_ready,
    input  dtrp_result_t result,
    output int           fail_count,
    output int           outstanding,
    output int           checked_count,
    output logic [8:0]   kinds_seen
);

    typedef enum logic [2:0] {
        SKIP_COMMENT,
        HDR,
        SEC_MAP,
        CYL_MAP,
        HEAD_MAP,
        REC_TYPE,
        FILL_BYTE,
        DATA_BYTES
    } parse_phase_t;

    parse_phase_t phase;
    logic [7:0]   mode_q;
    logic [7:0]   cyl_q;
    logic [7:0]   flags_q;
    logic [7:0]   count_q;
    logic [2:0]   code_q;
    logic [7:0]   entry_q;
    logic [12:0]  offset_q;
    logic         stopped;

    dtrp_result_t due_events[$];
    int           fails;
    int           checked;
    logic [8:0]   seen;

    task automatic expect_event(input logic [3:0] kind, input logic [7:0] idx,
                                input logic [12:0] off, input logic [7:0] val,
                                input logic lis, input logic lot);
        dtrp_result_t ev;
        ev.event_kind = kind;
        ev.track_cylinder = cyl_q;
        ev.track_head = flags_q[5:0];
        ev.track_mode = mode_q;
        ev.sector_count = count_q;
        ev.sector_bytes = 14'd128 << code_q;
        ev.sector_index = idx;
        ev.byte_offset = off;
        ev.value = val;
        ev.last_in_sector = lis;
        ev.last_of_track = lot;
        due_events.push_back(ev);
    endtask

    // step past a finished sector record, returns 1 when the track is done
    function automatic logic close_sector();
        if (int'(entry_q) + 1 >= int'(count_q))
        begin
            phase = HDR;
            entry_q = '0;
            return 1'b1;
        end
        entry_q = entry_q + 8'd1;
        phase = REC_TYPE;
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic is_end);
        logic [7:0]   idx;
        logic [12:0]  off;
        logic         lot;
        parse_phase_t cur;
        if (stopped)
            return;
        if (is_end)
        begin
            stopped = 1'b1;
            // only a track boundary makes a clean end
            if (phase == HDR && entry_q == 8'd0)
                expect_event(EV_END, '0, '0, '0, 1'b0, 1'b0);
            else
                expect_event(EV_ERROR, '0, '0, '0, 1'b0, 1'b0);
            return;
        end
        idx = entry_q;
        case (phase)
            SKIP_COMMENT:
                if (b == END_OF_COMMENT)
                begin
                    phase = HDR;
                    entry_q = '0;
                end
            HDR:
                if (entry_q < 8'd4)
                begin
                    case (entry_q)
                        8'd0: mode_q = b;
                        8'd1: cyl_q = b;
                        8'd2: flags_q = b;
                        default: count_q = b;
                    endcase
                    entry_q = entry_q + 8'd1;
                end
                else if (b > MAX_SIZE_CODE)
                begin
                    // old size code stays in the error result
                    stopped = 1'b1;
                    expect_event(EV_ERROR, '0, '0, '0, 1'b0, 1'b0);
                end
                else
                begin
                    code_q = b[2:0];
                    entry_q = '0;
                    if (count_q == 8'd0)
                        expect_event(EV_HEADER, '0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        phase = SEC_MAP;
                        expect_event(EV_HEADER, '0, '0, '0, 1'b0, 1'b0);
                    end
                end
            SEC_MAP, CYL_MAP, HEAD_MAP:
            begin
                cur = phase;
                if (int'(entry_q) + 1 >= int'(count_q))
                begin
                    entry_q = '0;
                    // flag bit 7 asks for a cylinder map, bit 6 for a head map
                    if (cur == SEC_MAP && flags_q[7])
                        phase = CYL_MAP;
                    else if (cur != HEAD_MAP && flags_q[6])
                        phase = HEAD_MAP;
                    else
                        phase = REC_TYPE;
                end
                else
                    entry_q = entry_q + 8'd1;
                expect_event(cur == SEC_MAP ? EV_SECMAP : cur == CYL_MAP ? EV_CYLMAP : EV_HEADMAP,
                             idx, '0, b, 1'b0, 1'b0);
            end
            REC_TYPE:
                if (b == TYPE_ABSENT)
                begin
                    lot = close_sector();
                    expect_event(EV_ABSENT, idx, '0, '0, 1'b1, lot);
                end
                else if (b == TYPE_FILL)
                    phase = FILL_BYTE;
                else
                begin
                    phase = DATA_BYTES;
                    offset_q = '0;
                end
            FILL_BYTE:
            begin
                lot = close_sector();
                expect_event(EV_FILL, idx, '0, b, 1'b1, lot);
            end
            default:
            begin
                off = offset_q;
                if (int'(off) + 1 >= (128 << code_q))
                begin
                    offset_q = '0;
                    lot = close_sector();
                    expect_event(EV_DATA, idx, off, b, 1'b1, lot);
                end
                else
                begin
                    offset_q = off + 13'd1;
                    expect_event(EV_DATA, idx, off, b, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: result %0d %s expected %0d, got %0d",
                     $time, checked, name, want, got);
            fails++;
        end
    endtask

    task automatic compare_result(input dtrp_result_t got);
        dtrp_result_t want;
        if (got.event_kind <= EV_ERROR)
            seen[got.event_kind] = 1'b1;
        if (due_events.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got kind %0d value %0d",
                     $time, got.event_kind, got.value);
            fails++;
            return;
        end
        want = due_events.pop_front();
        check_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
        check_field("track_cylinder", 16'(want.track_cylinder), 16'(got.track_cylinder));
        check_field("track_head", 16'(want.track_head), 16'(got.track_head));
        check_field("track_mode", 16'(want.track_mode), 16'(got.track_mode));
        check_field("sector_count", 16'(want.sector_count), 16'(got.sector_count));
        check_field("sector_bytes", 16'(want.sector_bytes), 16'(got.sector_bytes));
        check_field("sector_index", 16'(want.sector_index), 16'(got.sector_index));
        check_field("byte_offset", 16'(want.byte_offset), 16'(got.byte_offset));
        check_field("value", 16'(want.value), 16'(got.value));
        check_field("last_in_sector", 16'(want.last_in_sector), 16'(got.last_in_sector));
        check_field("last_of_track", 16'(want.last_of_track), 16'(got.last_of_track));
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = SKIP_COMMENT;
            mode_q = '0;
            cyl_q = '0;
            flags_q = '0;
            count_q = '0;
            code_q = '0;
            entry_q = '0;
            offset_q = '0;
            stopped = 1'b0;
            due_events.delete();
            fails = 0;
            checked = 0;
            seen = '0;
        end
        else
        begin
            if (item_valid && item_ready)
                decode_byte(item.byte_in, item.is_end);
            if (result_valid && result_ready)
                compare_result(result);
        end
        fail_count <= fails;
        outstanding <= due_events.size();
        checked_count <= checked;
        kinds_seen <= seen;
    end

endmodule

// ===== tb/tb_disk_image_track_record_parser.sv =====
`timescale 1ns / 1ps
// testbench top for the disk image track record parser: feeds image bytes with random
// gaps and stalls, gives the verdict; depends on dtrp_pkg and tb_track_record_checker

module tb_disk_image_track_record_parser;
    import dtrp_pkg::*;

    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;

    typedef enum {MIX_ANY, NO_DATA, ONLY_ABSENT, ONLY_FILL, ONLY_DATA} rec_mix_t;
    typedef enum {END_CLEAN, END_TRUNCATED, END_BAD_SIZE} image_end_t;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    dtrp_item_t   item;
    logic         result_valid;
    logic         result_ready;
    dtrp_result_t result;

    int           fail_count;
    int           outstanding;
    int           checked_count;
    logic [8:0]   kinds_seen;

    logic [7:0]   image_bytes[$];
    int           bytes_fed = 0;
    int           tx_left = 0;
    bit           tx_steady = 1'b0;
    image_end_t   ending;

    disk_image_track_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    tb_track_record_checker u_track_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .kinds_seen    (kinds_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("%0t: timed out, %0d results still outstanding", $time, outstanding);
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic e);
        int         gap;
        dtrp_item_t beat;
        if (tx_left == 0)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            tx_left = $urandom_range(20, 200);
        end
        tx_left--;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.byte_in = b;
        beat.is_end = e;
        item_valid <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (!item_ready);
        bytes_fed++;
    endtask

    // append one track to image_bytes: header, maps, then the sector records
    task automatic queue_track(input logic [7:0] mode, input logic [7:0] cyl,
                               input logic [7:0] flags, input logic [7:0] cnt,
                               input logic [7:0] code, input rec_mix_t mix);
        int         sector_len;
        int         roll;
        logic [7:0] rec_type;
        sector_len = (code <= MAX_SIZE_CODE) ? (128 << code) : 0;
        image_bytes.push_back(mode);
        image_bytes.push_back(cyl);
        image_bytes.push_back(flags);
        image_bytes.push_back(cnt);
        image_bytes.push_back(code);
        // sector map plus the cylinder and head maps the top flag bits ask for
        repeat (int'(cnt) * (1 + $countones(flags[7:6])))
            image_bytes.push_back(8'($urandom_range(0, 255)));
        for (int s = 0; s < int'(cnt); s++)
        begin
            roll = $urandom_range(0, 7);
            case (mix)
                ONLY_ABSENT: roll = 0;
                ONLY_FILL: roll = 3;
                ONLY_DATA: roll = 7;
                NO_DATA: roll = roll % 5;
                default:
                    if (code > 1 && roll > 4)
                        roll = 3;
            endcase
            // rolls 0-2 absent, 3-4 fill, 5-7 raw data
            if (roll < 3)
                image_bytes.push_back(TYPE_ABSENT);
            else if (roll < 5)
            begin
                image_bytes.push_back(TYPE_FILL);
                image_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                do
                    rec_type = 8'($urandom_range(0, 255));
                while (rec_type == TYPE_ABSENT || rec_type == TYPE_FILL);
                image_bytes.push_back(rec_type);
                repeat (sector_len) image_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic send_image(input int n);
        for (int k = 0; k < n; k++)
            send_beat(image_bytes[k], 1'b0);
        image_bytes.delete();
    endtask

    initial
    begin : result_sink
        int stall;
        int rx_left;
        int accepted;
        bit rx_steady;
        bit held;
        rx_left = 0;
        accepted = 0;
        rx_steady = 1'b0;
        held = 1'b0;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_left == 0)
            begin
                rx_steady = ($urandom_range(0, 2) == 0);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            // one long hold-off so the result queue fills and input backs up
            if (!held && accepted >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            accepted++;
        end
    end

    initial
    begin : stimulus
        int         random_start;
        int         track_no;
        int         cut;
        logic [7:0] cnt;
        logic [7:0] code;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short comment block
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_beat(END_OF_COMMENT, 1'b0);

        // empty track with mode, cylinder and head at their top
        queue_track(8'hff, 8'hff, 8'h3f, 8'd0, 8'd0, MIX_ANY);
        // both optional maps, largest size code, fill record
        queue_track(8'h00, 8'h00, 8'hff, 8'd1, 8'(MAX_SIZE_CODE), ONLY_FILL);
        // cylinder map only, absent record
        queue_track(8'h5a, 8'h01, 8'h80, 8'd1, 8'd3, ONLY_ABSENT);
        send_image(image_bytes.size());

        // one raw sector walked through every byte offset
        queue_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'd1, 8'd2, ONLY_DATA);
        send_image(image_bytes.size());

        random_start = bytes_fed;
        track_no = 0;
        while (bytes_fed < random_start + RANDOM_BYTES)
        begin
            track_no++;
            if (track_no == 2)
                queue_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'd255,
                            8'($urandom_range(0, MAX_SIZE_CODE)), NO_DATA);
            else
            begin
                cnt = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
                code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, MAX_SIZE_CODE))
                                                   : 8'd0;
                queue_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), cnt, code, MIX_ANY);
            end
            send_image(image_bytes.size());
        end

        ending = image_end_t'($urandom_range(0, 2));
        case (ending)
            END_CLEAN:
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            END_TRUNCATED:
            begin
                queue_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)), 8'd0,
                            MIX_ANY);
                cut = $urandom_range(1, image_bytes.size() - 1);
                send_image(cut);
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                queue_track(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)),
                            8'($urandom_range(MAX_SIZE_CODE + 1, 255)), NO_DATA);
                send_image(5);
            end
        endcase
        // parser is halted now, these bytes must give nothing
        repeat ($urandom_range(3, 10))
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("fed %0d image bytes, checked %0d results, event kinds seen %b",
                 bytes_fed, checked_count, kinds_seen);
        $display("image ended by %s, %0d mismatches, %0d results missing",
                 ending.name(), fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
